[rtl/sirs_pkg.sv]
// Shared constants and types for the signed integer to radix symbols core.
package sirs_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = 8;
    localparam int SYM_SLOTS   = 16;
    localparam int LEN_W       = 5;
    localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
    localparam int REM_W       = DIGIT_W + 1;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W      = $clog2(VALUE_BITS);
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [LEN_W-1:0]      RST_BASE_LENGTH  = 5'd10;
    localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_HIGH = 64'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_LENGTH  = 2'd0,
        REG_SYMBOLS_LOW  = 2'd1,
        REG_SYMBOLS_HIGH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]                  base_length;
        logic [SYM_SLOTS-1:0][SYM_W-1:0]   symbols;
    } cfg_t;

    typedef struct packed {
        logic                  err;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } job_t;

endpackage

[rtl/sirs_front.sv]
// Front end: accepts words, checks the symbol table and forms the magnitude.
module sirs_front (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [sirs_pkg::VALUE_BITS-1:0] s_value,
    input  sirs_pkg::cfg_t                   cfg,
    input  logic                             q_full,
    output logic                             q_push,
    output sirs_pkg::job_t                   q_job
);

    logic base_ok;

    always_comb begin
        logic [sirs_pkg::SYM_W-1:0] s;
        base_ok = (cfg.base_length >= sirs_pkg::LEN_W'(2)) &&
                  (cfg.base_length <= sirs_pkg::LEN_W'(sirs_pkg::MAX_SYMBOLS));
        for (int i = 0; i < sirs_pkg::SYM_SLOTS; i++) begin
            s = cfg.symbols[i];
            if (sirs_pkg::LEN_W'(i) < cfg.base_length) begin
                if (s == sirs_pkg::CHAR_NUL || s == sirs_pkg::CHAR_PLUS ||
                    s == sirs_pkg::CHAR_MINUS) begin
                    base_ok = 1'b0;
                end
                for (int j = i + 1; j < sirs_pkg::SYM_SLOTS; j++) begin
                    if (sirs_pkg::LEN_W'(j) < cfg.base_length && cfg.symbols[j] == s) begin
                        base_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign q_job.err = !base_ok;
    assign q_job.neg = s_value[sirs_pkg::VALUE_BITS-1];
    assign q_job.mag = s_value[sirs_pkg::VALUE_BITS-1] ?
                       (~s_value + sirs_pkg::VALUE_BITS'(1)) : s_value;

endmodule

[rtl/sirs_queue.sv]
// Two-entry job queue between the front end and the conversion engine.
module sirs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sirs_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sirs_pkg::job_t head
);

    sirs_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/sirs_back.sv]
// Conversion engine: bit-serial divider, digit store and symbol output.
module sirs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sirs_pkg::cfg_t                cfg,
    input  logic                          q_not_empty,
    input  sirs_pkg::job_t                q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sirs_pkg::SYM_W-1:0]    m_symbol,
    output logic                          m_last,
    output logic                          m_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                                state_reg;
    logic                                  neg_reg;
    logic [sirs_pkg::VALUE_BITS-1:0]       mag_reg;
    logic [sirs_pkg::VALUE_BITS-1:0]       quot_reg;
    logic [sirs_pkg::DIGIT_W-1:0]          rem_reg;
    logic [sirs_pkg::BIT_CNT_W-1:0]        bit_cnt_reg;
    logic [sirs_pkg::CNT_W-1:0]            cnt_reg;
    logic                                  m_valid_reg;
    logic [sirs_pkg::SYM_W-1:0]            m_symbol_reg;
    logic                                  m_last_reg;
    logic                                  m_status_reg;

    logic [sirs_pkg::DIGIT_W-1:0]          digit_mem [2**sirs_pkg::ADDR_W];
    logic [sirs_pkg::DIGIT_W-1:0]          rd_data_reg;

    logic                                  out_free;
    logic                                  out_load;
    logic [sirs_pkg::REM_W-1:0]            rem_shift;
    logic                                  ge;
    logic [sirs_pkg::REM_W-1:0]            rem_sub;
    logic [sirs_pkg::DIGIT_W-1:0]          rem_next;
    logic [sirs_pkg::VALUE_BITS-1:0]       quot_next;
    logic                                  last_bit;
    logic                                  mem_we;
    logic [sirs_pkg::CNT_W-1:0]            cnt_inc;
    logic [sirs_pkg::CNT_W-1:0]            cnt_dec;

    assign out_free  = !m_valid_reg || m_ready;
    assign rem_shift = {rem_reg, mag_reg[sirs_pkg::VALUE_BITS-1]};
    assign ge        = (rem_shift >= cfg.base_length);
    assign rem_sub   = rem_shift - cfg.base_length;
    assign rem_next  = ge ? rem_sub[sirs_pkg::DIGIT_W-1:0] : rem_shift[sirs_pkg::DIGIT_W-1:0];
    assign quot_next = {quot_reg[sirs_pkg::VALUE_BITS-2:0], ge};
    assign last_bit  = (bit_cnt_reg == sirs_pkg::BIT_CNT_W'(sirs_pkg::VALUE_BITS - 1));
    assign mem_we    = (state_reg == ST_DIV) && last_bit;
    assign cnt_inc   = cnt_reg + sirs_pkg::CNT_W'(1);
    assign cnt_dec   = cnt_reg - sirs_pkg::CNT_W'(1);
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty && (!q_head.err || out_free);
    assign out_load  = (q_pop && q_head.err) ||
                       ((state_reg == ST_SIGN) && neg_reg && out_free) ||
                       ((state_reg == ST_EMIT) && out_free);

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;
    assign m_status = m_status_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[cnt_reg[sirs_pkg::ADDR_W-1:0]] <= rem_next;
        end
        rd_data_reg <= digit_mem[cnt_dec[sirs_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            bit_cnt_reg <= '0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (q_head.err) begin
                            m_valid_reg  <= 1'b1;
                            m_symbol_reg <= sirs_pkg::CHAR_NUL;
                            m_last_reg   <= 1'b1;
                            m_status_reg <= 1'b1;
                            cnt_reg      <= '0;
                        end else begin
                            neg_reg     <= q_head.neg;
                            mag_reg     <= q_head.mag;
                            quot_reg    <= '0;
                            rem_reg     <= '0;
                            bit_cnt_reg <= '0;
                            cnt_reg     <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    bit_cnt_reg <= bit_cnt_reg + sirs_pkg::BIT_CNT_W'(1);
                    if (last_bit) begin
                        cnt_reg  <= cnt_inc;
                        mag_reg  <= quot_next;
                        quot_reg <= '0;
                        rem_reg  <= '0;
                        if (quot_next == '0 ||
                            cnt_inc == sirs_pkg::CNT_W'(sirs_pkg::VALUE_BITS)) begin
                            state_reg <= ST_SIGN;
                        end
                    end else begin
                        mag_reg  <= {mag_reg[sirs_pkg::VALUE_BITS-2:0], 1'b0};
                        quot_reg <= quot_next;
                        rem_reg  <= rem_next;
                    end
                end
                ST_SIGN: begin
                    if (!neg_reg) begin
                        state_reg <= ST_READ;
                    end else if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_symbol_reg <= sirs_pkg::CHAR_MINUS;
                        m_last_reg   <= 1'b0;
                        m_status_reg <= 1'b0;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_symbol_reg <= cfg.symbols[rd_data_reg];
                        m_last_reg   <= (cnt_reg == sirs_pkg::CNT_W'(1));
                        m_status_reg <= 1'b0;
                        cnt_reg      <= cnt_dec;
                        state_reg    <= (cnt_reg == sirs_pkg::CNT_W'(1)) ? ST_IDLE : ST_READ;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/signed_int_to_radix_symbols_core.sv]
// Top level of the signed integer to radix symbols core.
// Converts each signed 32-bit input word into its text in the radix set by
// base_length and the symbol table, most significant digit first, with a
// leading '-' for negative values; each output word carries one symbol and
// last marks the final one. An invalid table (fewer than two or more than 16
// symbols, a zero, '+' or '-' symbol, or a duplicate) gives one word with
// status set and no symbols. A two-entry queue lets the input side take words
// while the engine works. Each digit comes from a full pass of the bit-serial
// divider over the magnitude, and each symbol is read back from the digit
// store and then presented; an invalid-table word is answered from idle.
module signed_int_to_radix_symbols_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sirs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sirs_pkg::VALUE_BITS-1:0] s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sirs_pkg::SYM_W-1:0]            m_symbol,
    output logic                                  m_last,
    output logic                                  m_status
);

    logic [sirs_pkg::LEN_W-1:0]      base_length_reg;
    logic [sirs_pkg::CFG_DATA_W-1:0] symbols_low_reg;
    logic [sirs_pkg::CFG_DATA_W-1:0] symbols_high_reg;
    sirs_pkg::cfg_t                  cfg;
    logic                            q_full;
    logic                            q_push;
    sirs_pkg::job_t                  q_job;
    logic                            q_pop;
    logic                            q_not_empty;
    sirs_pkg::job_t                  q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg  <= sirs_pkg::RST_BASE_LENGTH;
            symbols_low_reg  <= sirs_pkg::RST_SYMBOLS_LOW;
            symbols_high_reg <= sirs_pkg::RST_SYMBOLS_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sirs_pkg::REG_BASE_LENGTH: begin
                    base_length_reg <= cfg_wdata[sirs_pkg::LEN_W-1:0];
                end
                sirs_pkg::REG_SYMBOLS_LOW: begin
                    symbols_low_reg <= cfg_wdata;
                end
                sirs_pkg::REG_SYMBOLS_HIGH: begin
                    symbols_high_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.base_length = base_length_reg;
    assign cfg.symbols     = {symbols_high_reg, symbols_low_reg};

    sirs_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_job)
    );

    sirs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sirs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_status    (m_status)
    );

endmodule
